@@ hw/rtl/positional_list_engine_unit_macros.svh @@
// Assertion macros shared by the positional list engine RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define PLM_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("positional list engine: invariant violated");

// When the antecedent holds, the consequent holds in the following cycle.
`define PLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list engine: sequence check failed");

`endif

@@ hw/rtl/plm_pkg.sv @@
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_POS  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [2:0]               command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;
    logic                     list_empty;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                strobe;
    cell_op_e            op;
    logic [IDX_W-1:0]    slot;
    logic [DATA_W-1:0]   value;
    logic [CNT_W-1:0]    count;
    logic                find_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/plm_cell.sv @@
// ----------------------------------------------------------------------------
// plm_cell
// One list element: shifts up on insert, down on delete, and captures its
// read tap and compare flag for the transaction being accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plm_cell
  import plm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  cell_index,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  output logic      [DATA_W-1:0] data,
  output logic      [DATA_W-1:0] tap,
  output logic                   match
);

  logic [CNT_W-1:0] index_ext;
  logic             at_slot;
  logic             past_slot;

  assign index_ext = CNT_W'(cell_index);
  assign at_slot   = (cell_index == ctrl.slot);
  assign past_slot = (cell_index > ctrl.slot);

  always_ff @(posedge clk) begin
    if (ctrl.strobe) begin
      // Taps see the contents before any shift of this transaction.
      tap   <= at_slot ? data : '0;
      match <= ctrl.find_en && (index_ext < ctrl.count) && (data == ctrl.value);
      case (ctrl.op)
        OP_OPEN: begin
          if (at_slot) begin
            data <= ctrl.value;
          end else if (past_slot) begin
            data <= left_data;
          end
        end
        OP_CLOSE: begin
          if (at_slot || past_slot) begin
            data <= right_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/plm_reduce.sv @@
// ----------------------------------------------------------------------------
// plm_reduce
// Combines the registered cell taps into the read value and the compare
// flags into the first matching 1-based position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plm_reduce
  import plm_pkg::*;
(
  input  wire logic [DATA_W-1:0] taps [CAPACITY],
  input  wire logic [CAPACITY-1:0] match_flags,
  output logic [DATA_W-1:0]      read_value,
  output logic [POS_W-1:0]       found_position
);

  // At most one tap is non-zero, so an OR gives the selected element.
  always_comb begin
    read_value = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      read_value = read_value | taps[k];
    end
  end

  // Scanning from the top lets the lowest match win.
  always_comb begin
    found_position = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match_flags[k]) begin
        found_position = POS_W'(k + 1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_valid/in_ready with in_data; each transaction gives
//   exactly one result on out_valid/out_ready with out_data.
//   Insert, delete and get address a 1-based position; find compares every
//   cell in parallel and reports the first match; clear empties the list.
// Pipeline and throughput:
//   Cells shift and capture their taps at the accepting edge; once the output
//   register is free, the tap reduction and the search for the first match
//   are registered into it and the result is raised on out_valid.
//   With the receiver ready, one command is accepted every cycle.
// Reset:
//   rst empties the list and drops any pending result. Cell contents are not
//   cleared; only cells below the current length are ever read.
// Stalls:
//   While a result waits in the output register and out_ready is low, one
//   further command may be accepted and held in the cells; after that
//   in_ready stays low until the output register is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_unit_macros.svh"

module positional_list_engine_unit
  import plm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              pend;
  logic              pend_rd_en;
  logic [1:0]        pend_status;
  logic [CNT_W-1:0]  pend_len;

  logic              in_fire;
  logic              out_free;
  logic              load_out;

  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    count_ext;
  logic              pos_nonzero;
  logic              ins_pos_ok;
  logic              rd_pos_ok;
  logic              is_full;
  logic [POS_W-1:0]  pos_m1;
  logic [1:0]        status_now;
  logic              rd_en_now;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [DATA_W-1:0]   cell_tap  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [DATA_W-1:0]   red_value;
  logic [POS_W-1:0]    red_found;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !pend || out_free;
  assign in_fire  = in_valid && in_ready;
  assign load_out = pend && out_free;

  assign pos_ext     = {1'b0, in_data.position};
  assign count_ext   = (POS_W + 1)'(count);
  assign pos_nonzero = (in_data.position != '0);
  assign ins_pos_ok  = pos_nonzero && (pos_ext <= count_ext + 1'b1);
  assign rd_pos_ok   = pos_nonzero && (pos_ext <= count_ext);
  assign is_full     = (count == CNT_W'(CAPACITY));
  assign pos_m1      = in_data.position - 1'b1;

  always_comb begin
    status_now   = ST_OK;
    rd_en_now    = 1'b0;
    count_next   = count;
    ctrl.strobe  = in_fire;
    ctrl.op      = OP_HOLD;
    ctrl.slot    = pos_m1[IDX_W-1:0];
    ctrl.value   = in_data.item_value;
    ctrl.count   = count;
    ctrl.find_en = 1'b0;
    case (cmd_e'(in_data.command))
      CMD_INSERT: begin
        if (!ins_pos_ok) begin
          status_now = ST_POS;
        end else if (is_full) begin
          status_now = ST_FULL;
        end else begin
          ctrl.op    = OP_OPEN;
          count_next = count + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (!rd_pos_ok) begin
          status_now = ST_POS;
        end else begin
          rd_en_now  = 1'b1;
          ctrl.op    = OP_CLOSE;
          count_next = count - 1'b1;
        end
      end
      CMD_GET: begin
        if (!rd_pos_ok) begin
          status_now = ST_POS;
        end else begin
          rd_en_now = 1'b1;
        end
      end
      CMD_FIND: begin
        ctrl.find_en = 1'b1;
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      ctrl.op = OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count <= count_next;
      end
      pend <= in_fire || (pend && !out_free);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_status <= status_now;
      pend_rd_en  <= rd_en_now;
      pend_len    <= count_next;
    end
    if (load_out) begin
      out_data.status         <= pend_status;
      out_data.read_value     <= pend_rd_en ? red_value : '0;
      out_data.found_position <= red_found;
      out_data.list_length    <= POS_W'(pend_len);
      out_data.list_empty     <= (pend_len == '0);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[0];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[CAPACITY-1];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    plm_cell u_cell (
      .clk        (clk),
      .cell_index (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i]),
      .match      (cell_match[i])
    );
  end

  plm_reduce u_reduce (
    .taps           (cell_tap),
    .match_flags    (cell_match),
    .read_value     (red_value),
    .found_position (red_found)
  );

  `PLM_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY))
  `PLM_ASSERT_ALWAYS(a_empty_flag,
      !out_valid || (out_data.list_empty == (out_data.list_length == '0)))
  `PLM_ASSERT_NEXT(a_full_hold,
      in_fire && is_full && (in_data.command == CMD_INSERT), count == $past(count))
  `PLM_ASSERT_NEXT(a_pend_kept, pend && !out_free, pend)
  `PLM_ASSERT_NEXT(a_error_no_change, in_fire && (status_now != ST_OK), count == $past(count))

endmodule

`default_nettype wire

@@ bench/tb_positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine.
// A shadow copy of the list predicts every result from the accepted commands.
// The bench runs a directed opening, then random bursts that grow, shrink,
// mix and scramble the list. Both handshakes idle at random, and one long
// receiver hold-off fills the engine so that it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;
  import plm_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RANDOM_ITEMS = 1800;
  localparam int IDLE_PCT     = 6;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AT      = 300;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 1000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [2:0] FIRST_SPARE_CMD = 3'd5;
  localparam logic [2:0] LAST_SPARE_CMD  = 3'd7;

  localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7fff_ffff;
  localparam logic [POS_W-1:0]         MAX_POS   = '1;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} burst_mode_e;

  // Shadow of the list contents and the queue of results still owed.
  class list_shadow;
    logic signed [DATA_W-1:0] cells [CAPACITY];
    int        count;
    out_item_t owed_results [$];
    int        mismatches;
    int        checked;
    int        pos_errors;
    int        full_errors;
    int        find_hits;

    function new();
      count       = 0;
      mismatches  = 0;
      checked     = 0;
      pos_errors  = 0;
      full_errors = 0;
      find_hits   = 0;
    endfunction

    function out_item_t apply_command(in_item_t c);
      out_item_t r;
      int        pos;
      r   = '0;
      pos = c.position;
      r.status = ST_OK;
      case (c.command)
        CMD_INSERT: begin
          if (pos < 1 || pos > count + 1) begin
            r.status = ST_POS;
          end else if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int k = count; k >= pos; k--) cells[k] = cells[k-1];
            cells[pos-1] = c.item_value;
            count++;
          end
        end
        CMD_DELETE: begin
          if (pos < 1 || pos > count) begin
            r.status = ST_POS;
          end else begin
            r.read_value = cells[pos-1];
            for (int k = pos; k < count; k++) cells[k-1] = cells[k];
            count--;
          end
        end
        CMD_GET: begin
          if (pos < 1 || pos > count) r.status = ST_POS;
          else r.read_value = cells[pos-1];
        end
        CMD_FIND: begin
          for (int k = 0; k < count; k++) begin
            if (cells[k] == c.item_value) begin
              r.found_position = POS_W'(k + 1);
              break;
            end
          end
        end
        CMD_CLEAR: count = 0;
        default: ;
      endcase
      if (r.status == ST_POS) pos_errors++;
      if (r.status == ST_FULL) full_errors++;
      if (r.found_position != 0) find_hits++;
      r.list_length = POS_W'(count);
      r.list_empty  = (count == 0);
      return r;
    endfunction

    function void note_command(in_item_t c);
      owed_results.push_back(apply_command(c));
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $error("result transaction with nothing expected: %p", got);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      checked++;
      compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("found_position", DATA_W'(want.found_position),
                    DATA_W'(got.found_position));
      compare_field("list_length", DATA_W'(want.list_length), DATA_W'(got.list_length));
      compare_field("list_empty", DATA_W'(want.list_empty), DATA_W'(got.list_empty));
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  list_shadow shadow;
  bit         calm;
  bit         hold_request;
  int         commands_sent;
  int         directed_sent;

  positional_list_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  function automatic in_item_t item(logic [2:0] cmd, int pos, logic signed [DATA_W-1:0] v);
    in_item_t c;
    c.command    = cmd;
    c.position   = POS_W'(pos);
    c.item_value = v;
    return c;
  endfunction

  // Small values repeat often, so finds hit duplicates and the first match matters.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) begin
      case ($urandom_range(3))
        0: v = MIN_VALUE;
        1: v = MAX_VALUE;
        2: v = '0;
        default: v = '1;
      endcase
    end else if (roll < 35) begin
      v = $urandom_range(7);
      v = v - 3;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(logic [2:0] cmd, int n);
    int limit;
    int roll;
    if (cmd != CMD_INSERT && cmd != CMD_DELETE && cmd != CMD_GET)
      return POS_W'($urandom_range(MAX_POS));
    limit = (cmd == CMD_INSERT) ? n + 1 : n;
    roll  = $urandom_range(99);
    if (roll < 8 || limit == 0) begin
      case ($urandom_range(2))
        0: return '0;
        1: return POS_W'(limit + 1);
        default: return POS_W'($urandom_range(MAX_POS, limit + 1));
      endcase
    end
    if (roll < 20) return POS_W'($urandom_range(1) ? 1 : limit);
    return POS_W'($urandom_range(limit, 1));
  endfunction

  function automatic in_item_t make_command(burst_mode_e mode);
    in_item_t c;
    int roll;
    int n;
    n    = shadow.count;
    roll = $urandom_range(99);
    c.item_value = pick_value();
    case (mode)
      MODE_GROW:
        c.command = roll < 75 ? CMD_INSERT : roll < 85 ? CMD_FIND :
                    roll < 93 ? CMD_GET : CMD_DELETE;
      MODE_SHRINK:
        c.command = roll < 70 ? CMD_DELETE : roll < 82 ? CMD_GET :
                    roll < 94 ? CMD_FIND : CMD_INSERT;
      MODE_MIXED:
        c.command = roll < 35 ? CMD_INSERT : roll < 60 ? CMD_DELETE :
                    roll < 78 ? CMD_GET : roll < 97 ? CMD_FIND : CMD_CLEAR;
      default:
        c.command = 3'($urandom_range(LAST_SPARE_CMD));
    endcase
    if (mode == MODE_NOISE) c.position = POS_W'($urandom_range(MAX_POS));
    else c.position = pick_position(c.command, n);
    if (c.command == CMD_FIND && n > 0 && $urandom_range(1))
      c.item_value = shadow.cells[$urandom_range(n - 1)];
    return c;
  endfunction

  // Holds the command on the bus until the engine takes it.
  task automatic send_command(in_item_t c);
    in_data  <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    shadow.note_command(c);
    commands_sent++;
  endtask

  task automatic issue(in_item_t c);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    send_command(c);
  endtask

  // Receiver: checks each result transaction and paces out_ready.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready === 1'b1)
        shadow.check_result(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("tb_positional_list_engine_unit: FAIL");
    $finish;
  end

  initial begin
    burst_mode_e mode;
    int          burst_len;
    int          random_sent;
    int          roll;
    shadow        = new();
    calm          = 1'b0;
    hold_request  = 1'b0;
    commands_sent = 0;
    random_sent   = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty list: bad positions, find and clear with nothing stored.
    issue(item(CMD_GET, 1, 0));
    issue(item(CMD_DELETE, 0, 0));
    issue(item(CMD_FIND, 0, 0));
    issue(item(CMD_CLEAR, 0, 0));
    issue(item(CMD_INSERT, 0, 5));
    issue(item(CMD_INSERT, 2, 5));
    // Build [0, -1, MIN, MAX] through front, end and middle inserts.
    issue(item(CMD_INSERT, 1, MIN_VALUE));
    issue(item(CMD_INSERT, 2, MAX_VALUE));
    issue(item(CMD_INSERT, 1, 0));
    issue(item(CMD_INSERT, 2, -1));
    issue(item(CMD_INSERT, MAX_POS, 9));
    issue(item(CMD_GET, 1, 0));
    issue(item(CMD_GET, 4, 0));
    issue(item(CMD_GET, 5, 0));
    issue(item(CMD_GET, 0, 0));
    issue(item(CMD_FIND, 0, MAX_VALUE));
    issue(item(CMD_FIND, 0, 12345));
    for (int code = FIRST_SPARE_CMD; code <= LAST_SPARE_CMD; code++)
      issue(item(3'(code), 1, -1));
    issue(item(CMD_DELETE, 5, 0));
    issue(item(CMD_DELETE, 2, 0));
    issue(item(CMD_DELETE, 3, 0));
    issue(item(CMD_FIND, 0, 0));
    issue(item(CMD_CLEAR, 0, 0));
    issue(item(CMD_GET, 1, 0));
    directed_sent = commands_sent;

    // The opening burst grows the list until inserts meet a full list.
    mode      = MODE_GROW;
    burst_len = 110;
    while (random_sent < RANDOM_ITEMS) begin
      for (int i = 0; i < burst_len && random_sent < RANDOM_ITEMS; i++) begin
        if (random_sent == HOLD_AT) hold_request = 1'b1;
        calm = (random_sent >= CALM_FROM && random_sent < CALM_TO);
        issue(make_command(mode));
        random_sent++;
      end
      roll      = $urandom_range(99);
      mode      = roll < 30 ? MODE_GROW : roll < 55 ? MODE_SHRINK :
                  roll < 85 ? MODE_MIXED : MODE_NOISE;
      burst_len = $urandom_range(120, 20);
    end
    in_valid <= 1'b0;

    while (shadow.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d directed) and checked %0d results.",
             commands_sent, directed_sent, shadow.checked);
    $display("Seen: %0d position errors, %0d full-list rejections, %0d find hits.",
             shadow.pos_errors, shadow.full_errors, shadow.find_hits);
    if (shadow.mismatches == 0) begin
      $display("tb_positional_list_engine_unit: PASS");
    end else begin
      $display("tb_positional_list_engine_unit: FAIL");
    end
    $finish;
  end

endmodule
